// ----- rtl/core/tsu_pkg.sv -----
`default_nettype none

package tsu_pkg;

    // Fixed field widths of the command and response channels.
    localparam int CMD_W      = 3;
    localparam int TID_PORT_W = 7;
    localparam int SEM_PORT_W = 4;
    localparam int INIT_W     = 16;
    localparam int VAL_W      = 64;
    localparam int OC_W       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE   = 3'd0,
        CMD_TICK     = 3'd1,
        CMD_EXIT     = 3'd2,
        CMD_JOIN     = 3'd3,
        CMD_SEM_INIT = 3'd4,
        CMD_SEM_WAIT = 3'd5,
        CMD_SEM_POST = 3'd6
    } t_cmd;

    typedef enum logic [OC_W-1:0] {
        OC_OK         = 3'd0,
        OC_INVALID    = 3'd1,
        OC_BLOCKED    = 3'd2,
        OC_ALL_EXITED = 3'd3,
        OC_FULL       = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_RUN   = 2'd1,
        ST_EXIT  = 2'd2,
        ST_BLOCK = 2'd3
    } t_thr_st;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_CR_FIRST,
        S_CR_NEW,
        S_CALL_RD,
        S_CALL_CHK,
        S_WAKE_RD,
        S_WAKE_CHK,
        S_JOIN_RD,
        S_JOIN_CHK,
        S_JOIN_VAL,
        S_BLOCK,
        S_POST_RD,
        S_POST_CHK,
        S_SC_ENTRY,
        S_SC_PREVCHK,
        S_SC_STEP,
        S_SC_CHK,
        S_SC_JV,
        S_DONE
    } t_state;

    // Write controls for the thread table; all writes share one address.
    typedef struct packed {
        logic    st_we;
        t_thr_st st_wdata;
        logic    ex_we;
        logic    jn_set;
        logic    jn_clr;
    } t_tbl_ctl;

    // Operations on the selected semaphore.
    typedef struct packed {
        logic init;
        logic dec;
        logic inc;
        logic push;
        logic pop;
    } t_sem_ctl;

    // Status of the selected semaphore.
    typedef struct packed {
        logic count_zero;
        logic count_max;
        logic wait_zero;
        logic wait_full;
    } t_sem_stat;

endpackage

`default_nettype wire

// ----- rtl/core/tsu_if.sv -----
`default_nettype none

// Command channel.
interface tsu_cmd_if import tsu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      command;
    logic [TID_PORT_W-1:0] target_thread;
    logic [SEM_PORT_W-1:0] sem_index;
    logic [INIT_W-1:0]     init_value;
    logic [VAL_W-1:0]      exit_value;

    modport source (
        output valid, command, target_thread, sem_index, init_value, exit_value,
        input  ready
    );
    modport sink (
        input  valid, command, target_thread, sem_index, init_value, exit_value,
        output ready
    );
endinterface

// Response channel.
interface tsu_rsp_if import tsu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [TID_PORT_W-1:0] running_thread;
    logic                  switched;
    logic [TID_PORT_W-1:0] new_thread_id;
    logic [VAL_W-1:0]      join_value;
    logic [OC_W-1:0]       outcome;

    modport source (
        output valid, running_thread, switched, new_thread_id, join_value, outcome,
        input  ready
    );
    modport sink (
        input  valid, running_thread, switched, new_thread_id, join_value, outcome,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/tsu_thread_table.sv -----
`default_nettype none

module tsu_thread_table import tsu_pkg::*; #(
    parameter int MAX_THREADS = 128,
    parameter int TID_W       = 7
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_tbl_ctl    i_ctl,
    input  wire [TID_W-1:0]  i_waddr,
    input  wire [VAL_W-1:0]  i_ex_wdata,
    input  wire [TID_W-1:0]  i_jn_wtgt,
    input  wire [TID_W-1:0]  i_raddr,
    input  wire [TID_W-1:0]  i_ex_raddr,
    output t_thr_st          o_st_rdata,
    output logic [TID_W-1:0] o_jn_rtgt,
    output logic             o_jn_rvalid,
    output logic [VAL_W-1:0] o_ex_rdata
);

    t_thr_st          r_status [MAX_THREADS];
    logic [VAL_W-1:0] r_exit   [MAX_THREADS];
    logic [TID_W-1:0] r_jtgt   [MAX_THREADS];
    logic [MAX_THREADS-1:0] r_jvalid;

    // Status memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.st_we) begin
            r_status[i_waddr] <= i_ctl.st_wdata;
        end
        o_st_rdata <= r_status[i_raddr];
    end

    // Exit value memory.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ex_we) begin
            r_exit[i_waddr] <= i_ex_wdata;
        end
        o_ex_rdata <= r_exit[i_ex_raddr];
    end

    // Join target memory, read alongside the status.
    always_ff @(posedge i_clk) begin
        if (i_ctl.jn_set) begin
            r_jtgt[i_waddr] <= i_jn_wtgt;
        end
        o_jn_rtgt   <= r_jtgt[i_raddr];
        o_jn_rvalid <= r_jvalid[i_raddr];
    end

    // Join valid bits are flip-flops so that reset marks every target invalid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jvalid <= '0;
        end else if (i_ctl.jn_set) begin
            r_jvalid[i_waddr] <= 1'b1;
        end else if (i_ctl.jn_clr) begin
            r_jvalid[i_waddr] <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/tsu_sem_bank.sv -----
`default_nettype none

module tsu_sem_bank import tsu_pkg::*; #(
    parameter int NUM_SEMAPHORES = 16,
    parameter int MAX_THREADS    = 128,
    parameter int COUNT_BITS     = 16,
    parameter int TID_W          = 7,
    parameter int CNT_W          = 8,
    parameter int SEM_W          = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire t_sem_ctl     i_ctl,
    input  wire [SEM_W-1:0]   i_sel,
    input  wire [INIT_W-1:0]  i_init_value,
    input  wire [TID_W-1:0]   i_push_id,
    output t_sem_stat         o_stat,
    output logic [TID_W-1:0]  o_pop_id
);

    localparam int SAT_W      = (COUNT_BITS > INIT_W) ? COUNT_BITS : INIT_W;
    localparam int RING_AW    = SEM_W + TID_W;
    localparam int RING_DEPTH = NUM_SEMAPHORES << TID_W;

    logic [COUNT_BITS-1:0] r_count [NUM_SEMAPHORES];
    logic [TID_W-1:0]      r_head  [NUM_SEMAPHORES];
    logic [CNT_W-1:0]      r_wait  [NUM_SEMAPHORES];
    logic [TID_W-1:0]      r_ring  [RING_DEPTH];

    logic [COUNT_BITS-1:0] w_count;
    logic [TID_W-1:0]      w_head;
    logic [CNT_W-1:0]      w_wait;
    logic [CNT_W:0]        w_slot_sum;
    logic [TID_W-1:0]      w_slot;
    logic [CNT_W-1:0]      w_head_inc;
    logic [TID_W-1:0]      w_head_next;
    logic [SAT_W-1:0]      w_init_ext;
    logic [COUNT_BITS-1:0] w_init_sat;

    assign w_count = r_count[i_sel];
    assign w_head  = r_head[i_sel];
    assign w_wait  = r_wait[i_sel];

    // Status of the selected semaphore.
    assign o_stat.count_zero = (w_count == '0);
    assign o_stat.count_max  = (w_count == '1);
    assign o_stat.wait_zero  = (w_wait == '0);
    assign o_stat.wait_full  = (w_wait >= CNT_W'(MAX_THREADS));

    // Tail slot of the ring: head plus waiting count, wrapped once.
    assign w_slot_sum = (CNT_W+1)'(w_head) + (CNT_W+1)'(w_wait);
    assign w_slot     = (w_slot_sum >= (CNT_W+1)'(MAX_THREADS))
                        ? TID_W'(w_slot_sum - (CNT_W+1)'(MAX_THREADS))
                        : TID_W'(w_slot_sum);

    assign w_head_inc  = CNT_W'(w_head) + CNT_W'(1);
    assign w_head_next = (w_head_inc >= CNT_W'(MAX_THREADS)) ? '0 : TID_W'(w_head_inc);

    // Starting count saturates to the counter width.
    assign w_init_ext = SAT_W'(i_init_value);
    assign w_init_sat = (w_init_ext > SAT_W'({COUNT_BITS{1'b1}}))
                        ? '1 : COUNT_BITS'(w_init_ext);

    // Counts and ring pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SEMAPHORES; k++) begin
                r_count[k] <= '0;
                r_head[k]  <= '0;
                r_wait[k]  <= '0;
            end
        end else begin
            if (i_ctl.init) begin
                r_count[i_sel] <= w_init_sat;
                r_head[i_sel]  <= '0;
                r_wait[i_sel]  <= '0;
            end else if (i_ctl.dec) begin
                r_count[i_sel] <= w_count - COUNT_BITS'(1);
            end else if (i_ctl.inc) begin
                r_count[i_sel] <= w_count + COUNT_BITS'(1);
            end else if (i_ctl.push) begin
                r_wait[i_sel] <= w_wait + CNT_W'(1);
            end else if (i_ctl.pop) begin
                r_head[i_sel] <= w_head_next;
                r_wait[i_sel] <= w_wait - CNT_W'(1);
            end
        end
    end

    // Wait ring memory, one row of slots per semaphore.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_ring[RING_AW'({i_sel, w_slot})] <= i_push_id;
        end
        if (i_ctl.pop) begin
            o_pop_id <= r_ring[RING_AW'({i_sel, w_head})];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/thread_scheduler_semaphore_unit.sv -----
// Channel   Direction  Interface   Payload
// i_cmd     in         tsu_cmd_if  command, target_thread, sem_index, init_value, exit_value
// o_rsp     out        tsu_rsp_if  running_thread, switched, new_thread_id, join_value, outcome
//
// One command at a time. A tick, an exit, and a join or semaphore wait that blocks end
// in a schedule, and an exit first checks every created thread for joiners to wake. The
// status memory has one read port and is scanned one entry at a time, each read followed
// by a check state. Reset clears the sequencer, the thread count, the current thread,
// join flags and semaphore counters; no clearing pass is needed. A new command is taken
// while a result still waits on o_rsp.
`default_nettype none

module thread_scheduler_semaphore_unit import tsu_pkg::*; #(
    parameter int MAX_THREADS    = 128,
    parameter int NUM_SEMAPHORES = 16,
    parameter int COUNT_BITS     = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tsu_cmd_if.sink    i_cmd,
    tsu_rsp_if.source  o_rsp
);

    localparam int TID_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam int SEM_W = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int CMP_W = (CNT_W > TID_PORT_W) ? CNT_W : TID_PORT_W;
    localparam int SIX_W = (SEM_W + 1 > SEM_PORT_W) ? SEM_W + 1 : SEM_PORT_W;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [TID_PORT_W-1:0] r_tgt, n_tgt;
    logic [SEM_PORT_W-1:0] r_si, n_si;
    logic [INIT_W-1:0]     r_ival, n_ival;
    logic [VAL_W-1:0]      r_xval, n_xval;
    logic [TID_W-1:0]      r_cur, n_cur;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [TID_W-1:0]      r_before, n_before;
    logic [TID_W-1:0]      r_newid, n_newid;
    logic [VAL_W-1:0]      r_jv, n_jv;
    t_outcome              r_oc, n_oc;
    logic                  r_blk, n_blk;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [TID_W-1:0]      r_cand, n_cand;

    logic                  r_ovalid, n_ovalid;
    logic [TID_PORT_W-1:0] r_o_thread, n_o_thread;
    logic                  r_o_sw, n_o_sw;
    logic [TID_PORT_W-1:0] r_o_newid, n_o_newid;
    logic [VAL_W-1:0]      r_o_jv, n_o_jv;
    t_outcome              r_o_oc, n_o_oc;

    t_tbl_ctl         tbl_ctl;
    logic [TID_W-1:0] tbl_waddr, tbl_raddr, tbl_ex_raddr;
    logic [VAL_W-1:0] tbl_ex_wdata;
    t_thr_st          tbl_st_rd;
    logic [TID_W-1:0] tbl_jn_tgt;
    logic             tbl_jn_valid;
    logic [VAL_W-1:0] tbl_ex_rd;

    t_sem_ctl         sem_ctl;
    t_sem_stat        sem_stat;
    logic [TID_W-1:0] sem_pop_id;

    logic             w_cur_ok;
    logic             w_si_ok;
    logic             w_join_ok;
    logic [CNT_W-1:0] w_cand_inc;
    logic [TID_W-1:0] w_next_cand;

    // Thread table and semaphore bank.
    tsu_thread_table #(
        .MAX_THREADS (MAX_THREADS),
        .TID_W       (TID_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (tbl_ctl),
        .i_waddr     (tbl_waddr),
        .i_ex_wdata  (tbl_ex_wdata),
        .i_jn_wtgt   (TID_W'(r_tgt)),
        .i_raddr     (tbl_raddr),
        .i_ex_raddr  (tbl_ex_raddr),
        .o_st_rdata  (tbl_st_rd),
        .o_jn_rtgt   (tbl_jn_tgt),
        .o_jn_rvalid (tbl_jn_valid),
        .o_ex_rdata  (tbl_ex_rd)
    );

    tsu_sem_bank #(
        .NUM_SEMAPHORES (NUM_SEMAPHORES),
        .MAX_THREADS    (MAX_THREADS),
        .COUNT_BITS     (COUNT_BITS),
        .TID_W          (TID_W),
        .CNT_W          (CNT_W),
        .SEM_W          (SEM_W)
    ) u_sem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (sem_ctl),
        .i_sel        (SEM_W'(r_si)),
        .i_init_value (r_ival),
        .i_push_id    (r_cur),
        .o_stat       (sem_stat),
        .o_pop_id     (sem_pop_id)
    );

    // Checks on the latched command.
    assign w_cur_ok  = (r_cnt != '0) && (CNT_W'(r_cur) < r_cnt);
    assign w_si_ok   = SIX_W'(r_si) < SIX_W'(NUM_SEMAPHORES);
    assign w_join_ok = (CMP_W'(r_tgt) < CMP_W'(r_cnt)) && (CMP_W'(r_tgt) != CMP_W'(r_cur));

    // Round-robin successor of the scan candidate.
    assign w_cand_inc  = CNT_W'(r_cand) + CNT_W'(1);
    assign w_next_cand = (w_cand_inc >= r_cnt) ? '0 : TID_W'(w_cand_inc);

    assign i_cmd.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.running_thread = r_o_thread;
    assign o_rsp.switched       = r_o_sw;
    assign o_rsp.new_thread_id  = r_o_newid;
    assign o_rsp.join_value     = r_o_jv;
    assign o_rsp.outcome        = r_o_oc;

    // Sequencer state and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_tgt      <= n_tgt;
        r_si       <= n_si;
        r_ival     <= n_ival;
        r_xval     <= n_xval;
        r_before   <= n_before;
        r_newid    <= n_newid;
        r_jv       <= n_jv;
        r_oc       <= n_oc;
        r_blk      <= n_blk;
        r_idx      <= n_idx;
        r_cand     <= n_cand;
        r_o_thread <= n_o_thread;
        r_o_sw     <= n_o_sw;
        r_o_newid  <= n_o_newid;
        r_o_jv     <= n_o_jv;
        r_o_oc     <= n_o_oc;
    end

    // Next state, table and semaphore controls.
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_tgt      = r_tgt;
        n_si       = r_si;
        n_ival     = r_ival;
        n_xval     = r_xval;
        n_cur      = r_cur;
        n_cnt      = r_cnt;
        n_before   = r_before;
        n_newid    = r_newid;
        n_jv       = r_jv;
        n_oc       = r_oc;
        n_blk      = r_blk;
        n_idx      = r_idx;
        n_cand     = r_cand;
        n_ovalid   = r_ovalid;
        n_o_thread = r_o_thread;
        n_o_sw     = r_o_sw;
        n_o_newid  = r_o_newid;
        n_o_jv     = r_o_jv;
        n_o_oc     = r_o_oc;

        tbl_ctl      = '0;
        tbl_waddr    = r_cur;
        tbl_raddr    = r_cur;
        tbl_ex_raddr = TID_W'(r_tgt);
        tbl_ex_wdata = r_xval;
        sem_ctl      = '0;

        // The response register empties on a transfer.
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd    = t_cmd'(i_cmd.command);
                    n_tgt    = i_cmd.target_thread;
                    n_si     = i_cmd.sem_index;
                    n_ival   = i_cmd.init_value;
                    n_xval   = i_cmd.exit_value;
                    n_before = r_cur;
                    n_newid  = '0;
                    n_jv     = '0;
                    n_oc     = OC_OK;
                    n_blk    = 1'b0;
                    n_state  = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_DONE;
                unique case (r_cmd) inside
                    CMD_CREATE: begin
                        n_state = (r_cnt == '0) ? S_CR_FIRST : S_CR_NEW;
                    end
                    CMD_TICK: begin
                        n_state = S_SC_ENTRY;
                    end
                    CMD_EXIT, CMD_JOIN, CMD_SEM_WAIT: begin
                        n_state = S_CALL_RD;
                    end
                    CMD_SEM_INIT: begin
                        if (!w_si_ok) begin
                            n_oc = OC_INVALID;
                        end else begin
                            sem_ctl.init = 1'b1;
                        end
                    end
                    CMD_SEM_POST: begin
                        if (!w_si_ok) begin
                            n_oc = OC_INVALID;
                        end else if (!sem_stat.wait_zero) begin
                            sem_ctl.pop = 1'b1;
                            n_state     = S_POST_RD;
                        end else if (!sem_stat.count_max) begin
                            sem_ctl.inc = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // The first create makes the caller thread 0 and running.
            S_CR_FIRST: begin
                tbl_waddr        = '0;
                tbl_ex_wdata     = '0;
                tbl_ctl.st_we    = 1'b1;
                tbl_ctl.st_wdata = ST_RUN;
                tbl_ctl.ex_we    = 1'b1;
                tbl_ctl.jn_clr   = 1'b1;
                n_cnt            = CNT_W'(1);
                n_cur            = '0;
                n_state          = S_CR_NEW;
            end

            S_CR_NEW: begin
                if (r_cnt >= CNT_W'(MAX_THREADS)) begin
                    n_oc = OC_FULL;
                end else begin
                    tbl_waddr        = TID_W'(r_cnt);
                    tbl_ex_wdata     = '0;
                    tbl_ctl.st_we    = 1'b1;
                    tbl_ctl.st_wdata = ST_READY;
                    tbl_ctl.ex_we    = 1'b1;
                    tbl_ctl.jn_clr   = 1'b1;
                    n_newid          = TID_W'(r_cnt);
                    n_cnt            = r_cnt + CNT_W'(1);
                end
                n_state = S_DONE;
            end

            // Caller check for exit, join and wait.
            S_CALL_RD: begin
                tbl_raddr = r_cur;
                n_state   = S_CALL_CHK;
            end

            S_CALL_CHK: begin
                n_state = S_DONE;
                if (!w_cur_ok || tbl_st_rd != ST_RUN
                        || (r_cmd == CMD_SEM_WAIT && !w_si_ok)
                        || (r_cmd == CMD_JOIN && !w_join_ok)) begin
                    n_oc = OC_INVALID;
                end else if (r_cmd == CMD_EXIT) begin
                    tbl_ctl.st_we    = 1'b1;
                    tbl_ctl.st_wdata = ST_EXIT;
                    tbl_ctl.ex_we    = 1'b1;
                    n_idx            = '0;
                    n_state          = S_WAKE_RD;
                end else if (r_cmd == CMD_JOIN) begin
                    n_state = S_JOIN_RD;
                end else if (!sem_stat.count_zero) begin
                    sem_ctl.dec = 1'b1;
                end else if (sem_stat.wait_full) begin
                    n_oc = OC_FULL;
                end else begin
                    sem_ctl.push = 1'b1;
                    n_state      = S_BLOCK;
                end
            end

            // Wake every thread blocked on a join of the exiting thread.
            S_WAKE_RD: begin
                if (r_idx >= r_cnt) begin
                    n_state = S_SC_ENTRY;
                end else begin
                    tbl_raddr = TID_W'(r_idx);
                    n_state   = S_WAKE_CHK;
                end
            end

            S_WAKE_CHK: begin
                if (tbl_jn_valid && tbl_jn_tgt == r_cur && tbl_st_rd == ST_BLOCK) begin
                    tbl_waddr        = TID_W'(r_idx);
                    tbl_ctl.st_we    = 1'b1;
                    tbl_ctl.st_wdata = ST_READY;
                end
                n_idx   = r_idx + CNT_W'(1);
                n_state = S_WAKE_RD;
            end

            // Join: an exited target completes at once, else the caller blocks.
            S_JOIN_RD: begin
                tbl_raddr = TID_W'(r_tgt);
                n_state   = S_JOIN_CHK;
            end

            S_JOIN_CHK: begin
                if (tbl_st_rd == ST_EXIT) begin
                    tbl_ex_raddr = TID_W'(r_tgt);
                    n_state      = S_JOIN_VAL;
                end else begin
                    n_state = S_BLOCK;
                end
            end

            S_JOIN_VAL: begin
                n_jv    = tbl_ex_rd;
                n_state = S_DONE;
            end

            S_BLOCK: begin
                tbl_ctl.st_we    = 1'b1;
                tbl_ctl.st_wdata = ST_BLOCK;
                tbl_ctl.jn_set   = (r_cmd == CMD_JOIN);
                n_blk            = 1'b1;
                n_state          = S_SC_ENTRY;
            end

            // Post with waiters: the head waiter becomes ready if still blocked.
            S_POST_RD: begin
                tbl_raddr = sem_pop_id;
                n_state   = S_POST_CHK;
            end

            S_POST_CHK: begin
                if (tbl_st_rd == ST_BLOCK) begin
                    tbl_waddr        = sem_pop_id;
                    tbl_ctl.st_we    = 1'b1;
                    tbl_ctl.st_wdata = ST_READY;
                end
                n_state = S_DONE;
            end

            // Scheduler: demote the running thread, then scan round-robin.
            S_SC_ENTRY: begin
                if (!w_cur_ok) begin
                    n_oc    = OC_ALL_EXITED;
                    n_state = S_DONE;
                end else begin
                    tbl_raddr = r_cur;
                    n_state   = S_SC_PREVCHK;
                end
            end

            S_SC_PREVCHK: begin
                if (tbl_st_rd == ST_RUN) begin
                    tbl_ctl.st_we    = 1'b1;
                    tbl_ctl.st_wdata = ST_READY;
                end
                n_cand  = r_cur;
                n_idx   = '0;
                n_state = S_SC_STEP;
            end

            S_SC_STEP: begin
                if (r_idx >= r_cnt) begin
                    n_oc    = OC_ALL_EXITED;
                    n_state = S_DONE;
                end else begin
                    n_cand    = w_next_cand;
                    tbl_raddr = w_next_cand;
                    n_idx     = r_idx + CNT_W'(1);
                    n_state   = S_SC_CHK;
                end
            end

            S_SC_CHK: begin
                if (tbl_st_rd == ST_READY) begin
                    tbl_waddr        = r_cand;
                    tbl_ctl.st_we    = 1'b1;
                    tbl_ctl.st_wdata = ST_RUN;
                    n_cur            = r_cand;
                    n_oc             = r_blk ? OC_BLOCKED : OC_OK;
                    if (tbl_jn_valid) begin
                        tbl_ctl.jn_clr = 1'b1;
                        tbl_ex_raddr   = tbl_jn_tgt;
                        n_state        = S_SC_JV;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_SC_STEP;
                end
            end

            S_SC_JV: begin
                n_jv    = tbl_ex_rd;
                n_state = S_DONE;
            end

            // Load the response register once it is free.
            S_DONE: begin
                if (!r_ovalid) begin
                    n_ovalid   = 1'b1;
                    n_o_thread = TID_PORT_W'(r_cur);
                    n_o_sw     = (r_cur != r_before);
                    n_o_newid  = TID_PORT_W'(r_newid);
                    n_o_jv     = r_jv;
                    n_o_oc     = r_oc;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The thread count never passes the table size.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_THREADS))
        else $error("thread count above table size");

    // The current thread always lies inside the created range.
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (CNT_W'(r_cur) < r_cnt))
        else $error("current thread outside created range");

    // A command transfer starts work and leaves the idle state.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> (r_state != S_IDLE))
        else $error("command taken without leaving idle");

    // A finished command always produces a pending response.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ovalid) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished command lost its response");
`endif

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb import tsu_pkg::*; ();

    localparam int NTHR = 128;
    localparam int NSEM = 16;
    localparam int CMAX = 65535;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 600;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [TID_PORT_W-1:0] tgt;
        logic [SEM_PORT_W-1:0] si;
        logic [INIT_W-1:0]     ival;
        logic [VAL_W-1:0]      xval;
    } t_cmd_item;

    typedef struct packed {
        logic [TID_PORT_W-1:0] run;
        logic                  sw;
        logic [TID_PORT_W-1:0] nid;
        logic [VAL_W-1:0]      jv;
        logic [OC_W-1:0]       oc;
    } t_rsp_item;

    typedef struct packed {
        t_cmd_item c;
        logic      fixed;
        t_rsp_item r;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm = 1'b0;
    int   err_cnt = 0;

    tsu_cmd_if cmd_bus ();
    tsu_rsp_if rsp_bus ();

    thread_scheduler_semaphore_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    // Clock with an 8-unit period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the thread table and semaphores.
    t_thr_st     thr_st [NTHR];
    logic [63:0] thr_xv [NTHR];
    bit          join_pend [NTHR];
    int          join_tgt [NTHR];
    int          cur_thr;
    int          thr_cnt;
    int          sem_cnt [NSEM];
    int          sem_ring [NSEM][NTHR];
    int          ring_hd [NSEM];
    int          ring_wt [NSEM];

    t_rsp_item expected_rsps[$];

    // Round-robin pick of the next ready thread, resuming a woken joiner.
    function automatic t_outcome pick_next_thread(inout logic [63:0] jv);
        int cand;
        if (thr_cnt == 0 || cur_thr >= thr_cnt) begin
            return OC_ALL_EXITED;
        end
        cand = cur_thr;
        if (thr_st[cur_thr] == ST_RUN) begin
            thr_st[cur_thr] = ST_READY;
        end
        for (int i = 0; i < thr_cnt; i++) begin
            cand = (cand + 1 >= thr_cnt) ? 0 : cand + 1;
            if (thr_st[cand] == ST_READY) begin
                thr_st[cand] = ST_RUN;
                cur_thr = cand;
                if (join_pend[cand]) begin
                    jv = thr_xv[join_tgt[cand]];
                    join_pend[cand] = 1'b0;
                end
                return OC_OK;
            end
        end
        return OC_ALL_EXITED;
    endfunction

    function automatic bit caller_running();
        return thr_cnt != 0 && cur_thr < thr_cnt && thr_st[cur_thr] == ST_RUN;
    endfunction

    // Applies one command to the shadow state and returns the response it gives.
    function automatic t_rsp_item apply_thread_cmd(t_cmd_item c);
        t_rsp_item   r;
        int          prev;
        int          tgt;
        int          si;
        int          slot;
        int          w;
        logic [63:0] jv;
        t_outcome    oc;
        prev = cur_thr;
        tgt  = int'(c.tgt);
        si   = int'(c.si);
        jv   = '0;
        oc   = OC_OK;
        r.nid = '0;
        case (c.cmd)
            CMD_CREATE: begin
                if (thr_cnt == 0) begin
                    thr_st[0] = ST_RUN;
                    thr_xv[0] = '0;
                    join_pend[0] = 1'b0;
                    cur_thr = 0;
                    thr_cnt = 1;
                end
                if (thr_cnt >= NTHR) begin
                    oc = OC_FULL;
                end else begin
                    thr_st[thr_cnt] = ST_READY;
                    thr_xv[thr_cnt] = '0;
                    join_pend[thr_cnt] = 1'b0;
                    r.nid = thr_cnt[6:0];
                    thr_cnt++;
                end
            end
            CMD_TICK: oc = pick_next_thread(jv);
            CMD_EXIT: begin
                if (!caller_running()) begin
                    oc = OC_INVALID;
                end else begin
                    thr_st[cur_thr] = ST_EXIT;
                    thr_xv[cur_thr] = c.xval;
                    // Wake every thread joined on the one that leaves.
                    for (int i = 0; i < thr_cnt; i++) begin
                        if (join_pend[i] && join_tgt[i] == cur_thr && thr_st[i] == ST_BLOCK) begin
                            thr_st[i] = ST_READY;
                        end
                    end
                    oc = pick_next_thread(jv);
                end
            end
            CMD_JOIN: begin
                if (!caller_running() || tgt >= thr_cnt || tgt == cur_thr) begin
                    oc = OC_INVALID;
                end else if (thr_st[tgt] == ST_EXIT) begin
                    jv = thr_xv[tgt];
                end else begin
                    thr_st[cur_thr] = ST_BLOCK;
                    join_pend[cur_thr] = 1'b1;
                    join_tgt[cur_thr] = tgt;
                    oc = (pick_next_thread(jv) == OC_OK) ? OC_BLOCKED : OC_ALL_EXITED;
                end
            end
            CMD_SEM_INIT: begin
                sem_cnt[si] = int'(c.ival);
                ring_hd[si] = 0;
                ring_wt[si] = 0;
            end
            CMD_SEM_WAIT: begin
                if (!caller_running()) begin
                    oc = OC_INVALID;
                end else if (sem_cnt[si] > 0) begin
                    sem_cnt[si]--;
                end else if (ring_wt[si] >= NTHR) begin
                    oc = OC_FULL;
                end else begin
                    slot = (ring_hd[si] + ring_wt[si]) % NTHR;
                    sem_ring[si][slot] = cur_thr;
                    ring_wt[si]++;
                    thr_st[cur_thr] = ST_BLOCK;
                    oc = (pick_next_thread(jv) == OC_OK) ? OC_BLOCKED : OC_ALL_EXITED;
                end
            end
            CMD_SEM_POST: begin
                if (ring_wt[si] > 0) begin
                    w = sem_ring[si][ring_hd[si]];
                    ring_hd[si] = (ring_hd[si] + 1) % NTHR;
                    ring_wt[si]--;
                    if (thr_st[w] == ST_BLOCK) begin
                        thr_st[w] = ST_READY;
                    end
                end else if (sem_cnt[si] < CMAX) begin
                    sem_cnt[si]++;
                end
            end
            default: ;
        endcase
        r.run = cur_thr[6:0];
        r.sw  = (cur_thr != prev);
        r.jv  = jv;
        r.oc  = oc;
        return r;
    endfunction

    // Opening commands; rows with fixed set carry the response typed in.
    t_plan_row plan [20] = '{
        '{'{CMD_TICK, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_ALL_EXITED}},
        '{'{CMD_EXIT, 7'd0, 4'd0, 16'd0, 64'd5}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_INVALID}},
        '{'{CMD_JOIN, 7'd1, 4'd0, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_INVALID}},
        '{'{CMD_SEM_WAIT, 7'd0, 4'd3, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_INVALID}},
        '{'{CMD_UNUSED, 7'd127, 4'd15, 16'hFFFF, '1}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_OK}},
        '{'{CMD_CREATE, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd1, 64'd0, OC_OK}},
        '{'{CMD_CREATE, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd2, 64'd0, OC_OK}},
        '{'{CMD_JOIN, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_INVALID}},
        '{'{CMD_JOIN, 7'd127, 4'd0, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_INVALID}},
        '{'{CMD_SEM_INIT, 7'd0, 4'd15, 16'hFFFF, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_OK}},
        '{'{CMD_SEM_POST, 7'd0, 4'd15, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_OK}},
        '{'{CMD_SEM_WAIT, 7'd0, 4'd15, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_OK}},
        '{'{CMD_SEM_INIT, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b1, '{7'd0, 1'b0, 7'd0, 64'd0, OC_OK}},
        '{'{CMD_SEM_WAIT, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b0, '0},
        '{'{CMD_JOIN, 7'd2, 4'd0, 16'd0, 64'd0}, 1'b0, '0},
        '{'{CMD_EXIT, 7'd0, 4'd0, 16'd0, '1}, 1'b0, '0},
        '{'{CMD_SEM_POST, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b0, '0},
        '{'{CMD_TICK, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b0, '0},
        '{'{CMD_EXIT, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b0, '0},
        '{'{CMD_TICK, 7'd0, 4'd0, 16'd0, 64'd0}, 1'b0, '0}
    };

    // Drives one command and returns once its transfer has taken place.
    task automatic send_cmd(t_cmd_item c, bit fixed, t_rsp_item typed);
        t_rsp_item r;
        while (!calm && $urandom_range(99) < 21) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.command       <= c.cmd;
        cmd_bus.target_thread <= c.tgt;
        cmd_bus.sem_index     <= c.si;
        cmd_bus.init_value    <= c.ival;
        cmd_bus.exit_value    <= c.xval;
        do @(posedge i_clk); while (!cmd_bus.ready);
        r = apply_thread_cmd(c);
        expected_rsps.push_back(fixed ? typed : r);
    endtask

    // Random command, weighted toward the ones that move threads around.
    function automatic t_cmd_item rand_cmd();
        t_cmd_item c;
        int        pick;
        pick = $urandom_range(99);
        if (pick < 6)       c.cmd = CMD_CREATE;
        else if (pick < 27) c.cmd = CMD_TICK;
        else if (pick < 37) c.cmd = CMD_EXIT;
        else if (pick < 51) c.cmd = CMD_JOIN;
        else if (pick < 59) c.cmd = CMD_SEM_INIT;
        else if (pick < 78) c.cmd = CMD_SEM_WAIT;
        else if (pick < 98) c.cmd = CMD_SEM_POST;
        else                c.cmd = CMD_UNUSED;
        if (thr_cnt > 0 && $urandom_range(3) != 0) begin
            c.tgt = TID_PORT_W'($urandom_range(thr_cnt - 1));
        end else begin
            c.tgt = TID_PORT_W'($urandom_range(127));
        end
        c.si = ($urandom_range(3) != 0) ? SEM_PORT_W'($urandom_range(3))
                                        : SEM_PORT_W'($urandom_range(15));
        case ($urandom_range(3))
            0:       c.ival = INIT_W'($urandom);
            1:       c.ival = 16'hFFFF;
            default: c.ival = INIT_W'($urandom_range(3));
        endcase
        c.xval = {$urandom, $urandom};
        return c;
    endfunction

    // Stimulus: directed rows, random traffic, filling the thread table, then more random traffic.
    initial begin
        t_cmd_item c;
        cmd_bus.valid         <= 1'b0;
        cmd_bus.command       <= '0;
        cmd_bus.target_thread <= '0;
        cmd_bus.sem_index     <= '0;
        cmd_bus.init_value    <= '0;
        cmd_bus.exit_value    <= '0;
        thr_cnt = 0;
        cur_thr = 0;
        for (int i = 0; i < NTHR; i++) join_pend[i] = 1'b0;
        for (int s = 0; s < NSEM; s++) begin
            sem_cnt[s] = 0;
            ring_hd[s] = 0;
            ring_wt[s] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (plan[k]) send_cmd(plan[k].c, plan[k].fixed, plan[k].r);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 300 && n < 420);
            send_cmd(rand_cmd(), 1'b0, '0);
        end
        calm = 1'b0;
        c = '0;
        c.cmd = CMD_CREATE;
        while (thr_cnt < NTHR) send_cmd(c, 1'b0, '0);
        send_cmd(c, 1'b1, '{cur_thr[6:0], 1'b0, 7'd0, 64'd0, OC_FULL});
        for (int n = 0; n < 40; n++) send_cmd(rand_cmd(), 1'b0, '0);
        cmd_bus.valid <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Response side stalls at random, except during the calm stretch.
    initial rsp_bus.ready = 1'b0;
    always @(posedge i_clk) begin
        rsp_bus.ready <= calm || ($urandom_range(99) >= 21);
    end

    // Compares each response transfer with the oldest expected response.
    always @(posedge i_clk) begin
        t_rsp_item e;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
                $error("response with none expected");
                err_cnt++;
            end else begin
                e = expected_rsps.pop_front();
                if (rsp_bus.running_thread !== e.run) begin
                    $error("running_thread: expected %0d, got %0d", e.run, rsp_bus.running_thread);
                    err_cnt++;
                end
                if (rsp_bus.switched !== e.sw) begin
                    $error("switched: expected %0d, got %0d", e.sw, rsp_bus.switched);
                    err_cnt++;
                end
                if (rsp_bus.new_thread_id !== e.nid) begin
                    $error("new_thread_id: expected %0d, got %0d", e.nid, rsp_bus.new_thread_id);
                    err_cnt++;
                end
                if (rsp_bus.join_value !== e.jv) begin
                    $error("join_value: expected %h, got %h", e.jv, rsp_bus.join_value);
                    err_cnt++;
                end
                if (rsp_bus.outcome !== e.oc) begin
                    $error("outcome: expected %0d, got %0d", e.oc, rsp_bus.outcome);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
